// File: src/ers_pkg.sv
package ers_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [TIMER_WIDTH-1:0] timer_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BEACON_CONFIRM = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DISTANCE_CONFIRM = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENTRY_HOLD = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXIT_HOLD = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DOOR_OPEN_TIMEOUT = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DOOR_CLOSE_TIMEOUT = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_FLOOR = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_USE_BEACON = 3'd7;

    // Floor call codes.
    localparam logic [1:0] FLOOR_NONE = 2'd0;
    localparam logic [1:0] FLOOR_ONE = 2'd1;
    localparam logic [1:0] FLOOR_TWO = 2'd2;

    localparam logic [1:0] START_FLOOR_RESET = FLOOR_TWO;

    typedef enum logic [3:0] {
        ST_FAR          = 4'd0,
        ST_CLOSE        = 4'd1,
        ST_CONFIRM      = 4'd2,
        ST_ENTRY_OPEN   = 4'd3,
        ST_ENTERED      = 4'd4,
        ST_ENTRY_CLOSED = 4'd5,
        ST_CALL_DEST    = 4'd6,
        ST_EXIT_OPEN    = 4'd7,
        ST_EXIT_SEEN    = 4'd8,
        ST_EXIT_CLEAR   = 4'd9,
        ST_FINISHED     = 4'd10,
        ST_ERROR        = 4'd11
    } flow_state_t;

    typedef struct packed {
        timer_t     beacon_confirm_ticks;
        timer_t     distance_confirm_ticks;
        timer_t     entry_hold_ticks;
        timer_t     exit_hold_ticks;
        timer_t     door_open_timeout_ticks;
        timer_t     door_close_timeout_ticks;
        logic [1:0] start_floor;
        logic       use_beacon;
    } cfg_t;

    typedef struct packed {
        logic beacon_near;
        logic robot_close;
        logic door_shut;
    } in_item_t;

    typedef struct packed {
        logic [3:0] flow_state;
        logic       service_on;
        logic       service_off;
        logic [1:0] call_floor;
        logic       hold_door;
        logic       release_door;
    } out_item_t;

    // Saturating increment of a tick counter.
    function automatic timer_t bump(input timer_t count);
        timer_t result;
        result = (count == '1) ? count : count + timer_t'(1);
        return result;
    endfunction

endpackage

// File: src/ers_fsm.sv
module ers_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  ers_pkg::in_item_t   item,
    input  ers_pkg::cfg_t       cfg,
    output ers_pkg::out_item_t  result
);

    ers_pkg::flow_state_t state_reg, state_next;
    ers_pkg::timer_t beacon_cnt_reg, beacon_cnt_next;
    ers_pkg::timer_t dist_cnt_reg, dist_cnt_next;
    ers_pkg::timer_t open_cnt_reg, open_cnt_next;
    ers_pkg::timer_t entry_cnt_reg, entry_cnt_next;
    ers_pkg::timer_t exit_cnt_reg, exit_cnt_next;
    ers_pkg::timer_t close_cnt_reg, close_cnt_next;
    logic entry_seen_reg, entry_seen_next;
    logic exit_timer_reg, exit_timer_next;

    logic            near;
    logic [1:0]      first_call;
    logic [1:0]      dest_call;
    logic            seen_now;
    logic            timer_now;
    ers_pkg::timer_t cnt_now;
    ers_pkg::timer_t cnt_bumped;

    assign near = cfg.use_beacon ? item.beacon_near : item.robot_close;
    assign first_call = (cfg.start_floor == ers_pkg::FLOOR_ONE) ?
                        ers_pkg::FLOOR_ONE : ers_pkg::FLOOR_TWO;
    assign dest_call = (cfg.start_floor == ers_pkg::FLOOR_ONE) ?
                       ers_pkg::FLOOR_TWO : ers_pkg::FLOOR_ONE;

    always_comb begin
        state_next = state_reg;
        beacon_cnt_next = beacon_cnt_reg;
        dist_cnt_next = dist_cnt_reg;
        open_cnt_next = open_cnt_reg;
        entry_cnt_next = entry_cnt_reg;
        exit_cnt_next = exit_cnt_reg;
        close_cnt_next = close_cnt_reg;
        entry_seen_next = entry_seen_reg;
        exit_timer_next = exit_timer_reg;
        seen_now = 1'b0;
        timer_now = 1'b0;
        cnt_now = '0;
        cnt_bumped = '0;
        result = '0;

        unique case (state_reg)
            ers_pkg::ST_FAR: begin
                if (near) begin
                    state_next = ers_pkg::ST_CLOSE;
                    beacon_cnt_next = '0;
                    dist_cnt_next = '0;
                end
            end
            ers_pkg::ST_CLOSE: begin
                if (!near) begin
                    state_next = ers_pkg::ST_FAR;
                    beacon_cnt_next = '0;
                end else begin
                    beacon_cnt_next = ers_pkg::bump(beacon_cnt_reg);
                    if (beacon_cnt_next >= cfg.beacon_confirm_ticks) begin
                        state_next = ers_pkg::ST_CONFIRM;
                        dist_cnt_next = '0;
                    end
                end
            end
            ers_pkg::ST_CONFIRM: begin
                if (!near) begin
                    state_next = ers_pkg::ST_FAR;
                    beacon_cnt_next = '0;
                    dist_cnt_next = '0;
                end else if (item.robot_close) begin
                    dist_cnt_next = ers_pkg::bump(dist_cnt_reg);
                    if (dist_cnt_next >= cfg.distance_confirm_ticks) begin
                        result.service_on = 1'b1;
                        result.call_floor = first_call;
                        state_next = ers_pkg::ST_ENTRY_OPEN;
                        open_cnt_next = '0;
                    end
                end else begin
                    dist_cnt_next = '0;
                end
            end
            ers_pkg::ST_ENTRY_OPEN, ers_pkg::ST_EXIT_OPEN: begin
                if (!item.door_shut) begin
                    result.hold_door = 1'b1;
                    open_cnt_next = '0;
                    if (state_reg == ers_pkg::ST_ENTRY_OPEN) begin
                        state_next = ers_pkg::ST_ENTERED;
                        entry_cnt_next = '0;
                        entry_seen_next = 1'b0;
                    end else begin
                        state_next = ers_pkg::ST_EXIT_SEEN;
                        exit_cnt_next = '0;
                        exit_timer_next = 1'b0;
                    end
                end else begin
                    open_cnt_next = ers_pkg::bump(open_cnt_reg);
                    if (open_cnt_next >= cfg.door_open_timeout_ticks) begin
                        state_next = ers_pkg::ST_ERROR;
                    end
                end
            end
            ers_pkg::ST_ENTERED: begin
                // The hold timer restarts on the first tick the robot is seen.
                seen_now = entry_seen_reg | item.robot_close;
                cnt_now = (item.robot_close && !entry_seen_reg) ? '0 : entry_cnt_reg;
                cnt_bumped = (seen_now && cnt_now < cfg.entry_hold_ticks) ?
                             ers_pkg::bump(cnt_now) : cnt_now;
                entry_seen_next = seen_now;
                entry_cnt_next = cnt_bumped;
                if (seen_now && cnt_bumped >= cfg.entry_hold_ticks &&
                    !item.robot_close) begin
                    result.release_door = 1'b1;
                    state_next = ers_pkg::ST_ENTRY_CLOSED;
                    close_cnt_next = '0;
                    entry_cnt_next = '0;
                end
            end
            ers_pkg::ST_ENTRY_CLOSED: begin
                if (item.door_shut) begin
                    state_next = ers_pkg::ST_CALL_DEST;
                    close_cnt_next = '0;
                end else begin
                    close_cnt_next = ers_pkg::bump(close_cnt_reg);
                    if (close_cnt_next >= cfg.door_close_timeout_ticks) begin
                        state_next = ers_pkg::ST_ERROR;
                    end
                end
            end
            ers_pkg::ST_CALL_DEST: begin
                result.call_floor = dest_call;
                state_next = ers_pkg::ST_EXIT_OPEN;
                open_cnt_next = '0;
            end
            ers_pkg::ST_EXIT_SEEN: begin
                if (item.robot_close) begin
                    state_next = ers_pkg::ST_EXIT_CLEAR;
                end
            end
            ers_pkg::ST_EXIT_CLEAR: begin
                if (!item.robot_close) begin
                    timer_now = 1'b1;
                    cnt_now = exit_timer_reg ? exit_cnt_reg : '0;
                    cnt_bumped = (cnt_now < cfg.exit_hold_ticks) ?
                                 ers_pkg::bump(cnt_now) : cnt_now;
                end
                exit_timer_next = timer_now;
                exit_cnt_next = cnt_bumped;
                if (timer_now && cnt_bumped >= cfg.exit_hold_ticks) begin
                    result.release_door = 1'b1;
                    result.service_off = 1'b1;
                    state_next = ers_pkg::ST_FINISHED;
                    close_cnt_next = '0;
                    exit_cnt_next = '0;
                    exit_timer_next = 1'b0;
                end
            end
            ers_pkg::ST_FINISHED: begin
                // Here the timeout is compared before the counter advances.
                if (item.door_shut || close_cnt_reg >= cfg.door_close_timeout_ticks) begin
                    state_next = ers_pkg::ST_FAR;
                    beacon_cnt_next = '0;
                    dist_cnt_next = '0;
                    entry_cnt_next = '0;
                    entry_seen_next = 1'b0;
                    exit_cnt_next = '0;
                    exit_timer_next = 1'b0;
                    close_cnt_next = '0;
                end else begin
                    close_cnt_next = ers_pkg::bump(close_cnt_reg);
                end
            end
            ers_pkg::ST_ERROR: begin
                result.release_door = 1'b1;
                result.service_off = 1'b1;
                state_next = ers_pkg::ST_FAR;
                beacon_cnt_next = '0;
                dist_cnt_next = '0;
                open_cnt_next = '0;
                entry_cnt_next = '0;
                exit_cnt_next = '0;
                close_cnt_next = '0;
                entry_seen_next = 1'b0;
                exit_timer_next = 1'b0;
            end
            default: begin
                state_next = ers_pkg::ST_FAR;
            end
        endcase

        result.flow_state = 4'(state_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ers_pkg::ST_FAR;
            beacon_cnt_reg <= '0;
            dist_cnt_reg <= '0;
            open_cnt_reg <= '0;
            entry_cnt_reg <= '0;
            exit_cnt_reg <= '0;
            close_cnt_reg <= '0;
            entry_seen_reg <= 1'b0;
            exit_timer_reg <= 1'b0;
        end else if (step) begin
            state_reg <= state_next;
            beacon_cnt_reg <= beacon_cnt_next;
            dist_cnt_reg <= dist_cnt_next;
            open_cnt_reg <= open_cnt_next;
            entry_cnt_reg <= entry_cnt_next;
            exit_cnt_reg <= exit_cnt_next;
            close_cnt_reg <= close_cnt_next;
            entry_seen_reg <= entry_seen_next;
            exit_timer_reg <= exit_timer_next;
        end
    end

endmodule

// File: src/elevator_ride_sequencer.sv
// A result is registered into the output register, or into the skid entry while that
// register is held. Throughput: one transaction per cycle while s_ready is high; the
// sequencer state and all tick counters update in the cycle a transaction is accepted,
// and a two-entry output buffer keeps input flowing while one result waits on m_ready.
// Reset (aresetn low, synchronous): state returns to far, counters and flags clear,
// configuration registers take their default values and the output buffer empties.
module elevator_ride_sequencer (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  ers_pkg::in_item_t                      s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output ers_pkg::out_item_t                     m_data,
    input  logic                                   cfg_wr_en,
    input  logic [ers_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [ers_pkg::CFG_DATA_WIDTH-1:0]     cfg_wr_data
);

    ers_pkg::cfg_t      cfg_reg;
    ers_pkg::out_item_t result;
    ers_pkg::out_item_t out_reg;
    ers_pkg::out_item_t skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               push;
    logic               pop;

    assign s_ready = !skid_valid_reg;
    assign push = s_valid && s_ready;
    assign pop = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beacon_confirm_ticks <= ers_pkg::timer_t'(100);
            cfg_reg.distance_confirm_ticks <= ers_pkg::timer_t'(50);
            cfg_reg.entry_hold_ticks <= ers_pkg::timer_t'(50);
            cfg_reg.exit_hold_ticks <= ers_pkg::timer_t'(50);
            cfg_reg.door_open_timeout_ticks <= ers_pkg::timer_t'(300);
            cfg_reg.door_close_timeout_ticks <= ers_pkg::timer_t'(120);
            cfg_reg.start_floor <= ers_pkg::START_FLOOR_RESET;
            cfg_reg.use_beacon <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ers_pkg::CFG_BEACON_CONFIRM:
                    cfg_reg.beacon_confirm_ticks <= cfg_wr_data;
                ers_pkg::CFG_DISTANCE_CONFIRM:
                    cfg_reg.distance_confirm_ticks <= cfg_wr_data;
                ers_pkg::CFG_ENTRY_HOLD:
                    cfg_reg.entry_hold_ticks <= cfg_wr_data;
                ers_pkg::CFG_EXIT_HOLD:
                    cfg_reg.exit_hold_ticks <= cfg_wr_data;
                ers_pkg::CFG_DOOR_OPEN_TIMEOUT:
                    cfg_reg.door_open_timeout_ticks <= cfg_wr_data;
                ers_pkg::CFG_DOOR_CLOSE_TIMEOUT:
                    cfg_reg.door_close_timeout_ticks <= cfg_wr_data;
                ers_pkg::CFG_START_FLOOR:
                    cfg_reg.start_floor <= cfg_wr_data[1:0];
                ers_pkg::CFG_USE_BEACON:
                    cfg_reg.use_beacon <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    ers_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (push),
        .item    (s_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // The skid entry only fills when the output register is occupied and not drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                out_reg <= result;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_reg <= result;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg <= result;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

// File: src/ers_checker.sv
module ers_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input ers_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input ers_pkg::out_item_t m_data
);

    // A stalled result transaction must hold its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Every accepted input is followed in the next cycle by a valid result on the output.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !$isunknown(s_data) |=> m_valid)
        else $error("no result after accepted input");

    a_service_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.service_on |->
            m_data.flow_state == 4'(ers_pkg::ST_ENTRY_OPEN) &&
            m_data.call_floor != ers_pkg::FLOOR_NONE)
        else $error("service_on outside the entry call");

    a_hold_door: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hold_door |->
            m_data.flow_state == 4'(ers_pkg::ST_ENTERED) ||
            m_data.flow_state == 4'(ers_pkg::ST_EXIT_SEEN))
        else $error("hold_door with an unexpected state");

    a_service_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.service_off |->
            m_data.release_door &&
            (m_data.flow_state == 4'(ers_pkg::ST_FAR) ||
             m_data.flow_state == 4'(ers_pkg::ST_FINISHED)))
        else $error("service_off without release or in a wrong state");

endmodule

bind elevator_ride_sequencer ers_checker u_ers_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ers_pkg::*;

    localparam int unsigned RIDE_PHASES     = 14;
    localparam int unsigned TICKS_PER_PHASE = 66;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned OPENING_TICKS   = 25;

    // Three short rides under zero thresholds, as {beacon_near, robot_close, door_shut}:
    // a door that never opens, a door that never closes, and a complete ride.
    localparam logic [2:0] OPENING [OPENING_TICKS] = '{
        3'b100, 3'b100, 3'b110, 3'b101, 3'b000,
        3'b100, 3'b100, 3'b110, 3'b110, 3'b010, 3'b000, 3'b000, 3'b000,
        3'b100, 3'b100, 3'b110, 3'b100, 3'b010, 3'b000, 3'b001, 3'b000,
        3'b000, 3'b010, 3'b000, 3'b000
    };

    class ride_tracker;
        cfg_t        regs;
        flow_state_t state;
        timer_t      beacon_cnt, dist_cnt, open_cnt, entry_cnt, exit_cnt, close_cnt;
        bit          entry_seen, exit_armed;
        out_item_t   due[$];
        int unsigned faults, reported, checked, rides_done, door_faults;
        logic [15:0] states_seen;

        function new();
            regs.beacon_confirm_ticks     = 16'd100;
            regs.distance_confirm_ticks   = 16'd50;
            regs.entry_hold_ticks         = 16'd50;
            regs.exit_hold_ticks          = 16'd50;
            regs.door_open_timeout_ticks  = 16'd300;
            regs.door_close_timeout_ticks = 16'd120;
            regs.start_floor              = START_FLOOR_RESET;
            regs.use_beacon               = 1'b1;
            state       = ST_FAR;
            open_cnt    = '0;
            states_seen = '0;
            clear_counts();
        endfunction

        function void clear_counts();
            beacon_cnt = '0;
            dist_cnt   = '0;
            open_cnt   = '0;
            entry_cnt  = '0;
            exit_cnt   = '0;
            close_cnt  = '0;
            entry_seen = 1'b0;
            exit_armed = 1'b0;
        endfunction

        function timer_t step_up(timer_t c);
            return (&c) ? c : c + timer_t'(1);
        endfunction

        function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
            case (idx)
                CFG_BEACON_CONFIRM:     regs.beacon_confirm_ticks = value;
                CFG_DISTANCE_CONFIRM:   regs.distance_confirm_ticks = value;
                CFG_ENTRY_HOLD:         regs.entry_hold_ticks = value;
                CFG_EXIT_HOLD:          regs.exit_hold_ticks = value;
                CFG_DOOR_OPEN_TIMEOUT:  regs.door_open_timeout_ticks = value;
                CFG_DOOR_CLOSE_TIMEOUT: regs.door_close_timeout_ticks = value;
                CFG_START_FLOOR:        regs.start_floor = value[1:0];
                CFG_USE_BEACON:         regs.use_beacon = value[0];
                default: ;
            endcase
        endfunction

        // Advances the ride by one accepted tick and queues the outputs it must produce.
        function void note_tick(in_item_t it);
            out_item_t   res;
            logic        near;
            logic [1:0]  first_call, dest_call;
            flow_state_t s;
            near       = regs.use_beacon ? it.beacon_near : it.robot_close;
            first_call = (regs.start_floor == FLOOR_ONE) ? FLOOR_ONE : FLOOR_TWO;
            dest_call  = (regs.start_floor == FLOOR_ONE) ? FLOOR_TWO : FLOOR_ONE;
            res = '0;
            s   = state;
            case (state)
                ST_FAR: if (near) begin
                    s = ST_CLOSE;
                    beacon_cnt = '0;
                    dist_cnt = '0;
                end
                ST_CLOSE: if (!near) begin
                    s = ST_FAR;
                    beacon_cnt = '0;
                end else begin
                    beacon_cnt = step_up(beacon_cnt);
                    if (beacon_cnt >= regs.beacon_confirm_ticks) begin
                        s = ST_CONFIRM;
                        dist_cnt = '0;
                    end
                end
                ST_CONFIRM: if (!near) begin
                    s = ST_FAR;
                    beacon_cnt = '0;
                    dist_cnt = '0;
                end else if (it.robot_close) begin
                    dist_cnt = step_up(dist_cnt);
                    if (dist_cnt >= regs.distance_confirm_ticks) begin
                        res.service_on = 1'b1;
                        res.call_floor = first_call;
                        s = ST_ENTRY_OPEN;
                        open_cnt = '0;
                    end
                end else begin
                    dist_cnt = '0;
                end
                ST_ENTRY_OPEN, ST_EXIT_OPEN: if (!it.door_shut) begin
                    res.hold_door = 1'b1;
                    open_cnt = '0;
                    if (state == ST_ENTRY_OPEN) begin
                        s = ST_ENTERED;
                        entry_cnt = '0;
                        entry_seen = 1'b0;
                    end else begin
                        s = ST_EXIT_SEEN;
                        exit_cnt = '0;
                        exit_armed = 1'b0;
                    end
                end else begin
                    open_cnt = step_up(open_cnt);
                    if (open_cnt >= regs.door_open_timeout_ticks) s = ST_ERROR;
                end
                ST_ENTERED: begin
                    if (it.robot_close && !entry_seen) begin
                        entry_seen = 1'b1;
                        entry_cnt = '0;
                    end
                    if (entry_seen && entry_cnt < regs.entry_hold_ticks)
                        entry_cnt = step_up(entry_cnt);
                    if (entry_seen && entry_cnt >= regs.entry_hold_ticks && !it.robot_close) begin
                        res.release_door = 1'b1;
                        s = ST_ENTRY_CLOSED;
                        close_cnt = '0;
                        entry_cnt = '0;
                    end
                end
                ST_ENTRY_CLOSED: if (it.door_shut) begin
                    s = ST_CALL_DEST;
                    close_cnt = '0;
                end else begin
                    close_cnt = step_up(close_cnt);
                    if (close_cnt >= regs.door_close_timeout_ticks) s = ST_ERROR;
                end
                ST_CALL_DEST: begin
                    res.call_floor = dest_call;
                    s = ST_EXIT_OPEN;
                    open_cnt = '0;
                end
                ST_EXIT_SEEN: if (it.robot_close) s = ST_EXIT_CLEAR;
                ST_EXIT_CLEAR: begin
                    if (!it.robot_close) begin
                        if (!exit_armed) begin
                            exit_armed = 1'b1;
                            exit_cnt = '0;
                        end
                        if (exit_cnt < regs.exit_hold_ticks) exit_cnt = step_up(exit_cnt);
                    end else begin
                        exit_armed = 1'b0;
                        exit_cnt = '0;
                    end
                    if (exit_armed && exit_cnt >= regs.exit_hold_ticks) begin
                        res.release_door = 1'b1;
                        res.service_off = 1'b1;
                        s = ST_FINISHED;
                        close_cnt = '0;
                        exit_cnt = '0;
                        exit_armed = 1'b0;
                    end
                end
                // The finished state compares before it counts, unlike every other wait.
                ST_FINISHED: if (it.door_shut || close_cnt >= regs.door_close_timeout_ticks) begin
                    s = ST_FAR;
                    beacon_cnt = '0;
                    dist_cnt = '0;
                    entry_cnt = '0;
                    entry_seen = 1'b0;
                    exit_cnt = '0;
                    exit_armed = 1'b0;
                    close_cnt = '0;
                end else begin
                    close_cnt = step_up(close_cnt);
                end
                ST_ERROR: begin
                    res.release_door = 1'b1;
                    res.service_off = 1'b1;
                    s = ST_FAR;
                    clear_counts();
                end
                default: s = ST_FAR;
            endcase
            if (s == ST_FINISHED && state != ST_FINISHED) rides_done++;
            if (s == ST_ERROR) door_faults++;
            state = s;
            states_seen[s] = 1'b1;
            res.flow_state = s;
            due.push_back(res);
        endfunction

        function void check_tick(out_item_t got);
            out_item_t want;
            if (due.size() == 0) begin
                faults++;
                if (reported < 10) begin
                    reported++;
                    $display("result with no tick outstanding: %p", got);
                end
                return;
            end
            want = due.pop_front();
            checked++;
            if (got.flow_state !== want.flow_state || got.service_on !== want.service_on ||
                got.service_off !== want.service_off || got.call_floor !== want.call_floor ||
                got.hold_door !== want.hold_door || got.release_door !== want.release_door) begin
                faults++;
                if (reported < 10) begin
                    reported++;
                    $display("result %0d mismatch (expected/actual): state %0d/%0d on %b/%b",
                             checked, want.flow_state, got.flow_state,
                             want.service_on, got.service_on);
                    $display("    off %b/%b call %0d/%0d hold %b/%b release %b/%b",
                             want.service_off, got.service_off, want.call_floor, got.call_floor,
                             want.hold_door, got.hold_door, want.release_door, got.release_door);
                end
            end
        endfunction

        // Picks the next sensor sample, mostly one that moves the ride forward.
        function in_item_t next_item(int unsigned eager, bit door_fault);
            in_item_t   it;
            logic [2:0] raw;
            bit         stuck;
            raw = 3'($urandom_range(0, 7));
            it  = raw;
            if ($urandom_range(1, 100) > eager) return it;
            stuck = door_fault ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 1);
            case (state)
                ST_FAR, ST_CLOSE: if (regs.use_beacon) it.beacon_near = 1'b1;
                                  else it.robot_close = 1'b1;
                ST_CONFIRM: begin
                    it.robot_close = 1'b1;
                    if (regs.use_beacon) it.beacon_near = 1'b1;
                end
                ST_ENTRY_OPEN, ST_EXIT_OPEN: it.door_shut = stuck;
                ST_ENTERED: it.robot_close = !entry_seen ||
                    (entry_cnt < regs.entry_hold_ticks && $urandom_range(0, 1) == 1);
                ST_ENTRY_CLOSED: it.door_shut = !stuck;
                ST_EXIT_SEEN: it.robot_close = 1'b1;
                ST_EXIT_CLEAR: it.robot_close = 1'b0;
                default: ;
            endcase
            return it;
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    in_item_t                   s_data;
    logic                       m_valid;
    logic                       m_ready;
    out_item_t                  m_data;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wr_data;

    int unsigned cycles = 0;
    int unsigned settings_loaded = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    ride_tracker ride = new();

    elevator_ride_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycles, ride.due.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic timer_t draw_limit(int unsigned hi);
        return ($urandom_range(0, 11) == 0) ? timer_t'(0) : timer_t'($urandom_range(1, hi));
    endfunction

    function automatic cfg_t uniform_limits(timer_t v, logic [1:0] floor_sel, logic beacon_sel);
        cfg_t c;
        c.beacon_confirm_ticks     = v;
        c.distance_confirm_ticks   = v;
        c.entry_hold_ticks         = v;
        c.exit_hold_ticks          = v;
        c.door_open_timeout_ticks  = v;
        c.door_close_timeout_ticks = v;
        c.start_floor              = floor_sel;
        c.use_beacon               = beacon_sel;
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        ride.set_reg(idx, value);
    endtask

    // The narrow registers get random upper bits, which the block must ignore.
    task automatic load_settings(input cfg_t c);
        write_reg(CFG_BEACON_CONFIRM, c.beacon_confirm_ticks);
        write_reg(CFG_DISTANCE_CONFIRM, c.distance_confirm_ticks);
        write_reg(CFG_ENTRY_HOLD, c.entry_hold_ticks);
        write_reg(CFG_EXIT_HOLD, c.exit_hold_ticks);
        write_reg(CFG_DOOR_OPEN_TIMEOUT, c.door_open_timeout_ticks);
        write_reg(CFG_DOOR_CLOSE_TIMEOUT, c.door_close_timeout_ticks);
        write_reg(CFG_START_FLOOR, {14'($urandom), c.start_floor});
        write_reg(CFG_USE_BEACON, {15'($urandom), c.use_beacon});
        cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    task automatic send_tick(input in_item_t it);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        ride.note_tick(it);
    endtask

    // Holds the sender off until every outstanding result has been returned.
    task automatic settle();
        s_valid <= 1'b0;
        while (ride.due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        cfg_t        plan;
        int unsigned eager;
        bit          door_fault;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_wr_data <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero thresholds with an out-of-range start floor.
        load_settings(uniform_limits('0, 2'd0, 1'b1));
        foreach (OPENING[i]) send_tick(in_item_t'(OPENING[i]));
        settle();

        for (int p = 1; p <= RIDE_PHASES; p++) begin
            eager      = $urandom_range(70, 95);
            door_fault = ($urandom_range(0, 2) == 0);
            if (p == 1) begin
                plan = uniform_limits(16'd1, 2'd3, 1'b0);
            end else if (p == 2) begin
                plan = uniform_limits('1, FLOOR_ONE, 1'b1);
            end else begin
                plan.beacon_confirm_ticks     = draw_limit(5);
                plan.distance_confirm_ticks   = draw_limit(5);
                plan.entry_hold_ticks         = draw_limit(6);
                plan.exit_hold_ticks          = draw_limit(6);
                plan.door_open_timeout_ticks  = draw_limit(8);
                plan.door_close_timeout_ticks = draw_limit(8);
                plan.start_floor              = 2'($urandom_range(0, 3));
                plan.use_beacon               = 1'($urandom_range(0, 1));
            end
            load_settings(plan);
            repeat (TICKS_PER_PHASE) send_tick(ride.next_item(eager, door_fault));
            settle();
        end

        $display("%0d ticks checked under %0d register settings: %0d rides completed, %0d errors",
                 ride.checked, settings_loaded, ride.rides_done, ride.door_faults);
        $display("flow states visited %b, %0d mismatches", ride.states_seen[11:0], ride.faults);
        if (ride.faults == 0 && ride.due.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            // m_data is sampled before the edge's updates, so this is the accepted transaction.
            ride.check_tick(m_data);
        end
    end

endmodule
